/* design/bus_telegram_field_extractor_macros.svh */
// Assertion macros used by the telegram extractor top module.
// Set ASSERT_OFF to compile the checks away.
`ifndef BUS_TELEGRAM_FIELD_EXTRACTOR_MACROS_SVH
`define BUS_TELEGRAM_FIELD_EXTRACTOR_MACROS_SVH

`ifndef ASSERT_OFF
// A property that must hold at every clock edge outside reset.
`define BTFE_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("btfe assertion failed");
// A condition that must never be seen outside reset.
`define BTFE_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("btfe forbidden condition seen");
`else
`define BTFE_ASSERT(label, clk, rst_n, prop)
`define BTFE_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

/* design/btfe_pkg.sv */
package btfe_pkg;

    localparam int BYTE_W      = 8;
    localparam int DS_W        = 2;
    localparam int RAW_W       = 16;
    localparam int SCALED_W    = 24;
    localparam int PATTERN_W   = 64;
    localparam int FORMAT_W    = 32;
    localparam int DIVISOR_W   = 16;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 64;

    localparam logic [SCALED_W-1:0] SCALED_MAX   = 24'hFFFFFF;
    localparam logic [FORMAT_W-1:0] FORMAT_RESET = 32'h0001_0111;

    // Register groups, selected by the upper two bits of the index.
    localparam logic [1:0] CFG_GROUP_PATTERN = 2'd0;
    localparam logic [1:0] CFG_GROUP_FORMAT  = 2'd1;

    typedef struct packed {
        logic [DIVISOR_W-1:0] divisor;
        logic [2:0]           unused;
        logic                 two_byte;
        logic [7:0]           skip_count;
        logic [3:0]           header_len;
    } btfe_format_t;

    typedef struct packed {
        logic busy;
        logic done;
    } btfe_div_status_t;

endpackage

/* design/btfe_if.sv */
interface btfe_byte_if;
    import btfe_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface btfe_result_if;
    import btfe_pkg::*;

    logic                valid;
    logic                ready;
    logic [DS_W-1:0]     dataset_index;
    logic [RAW_W-1:0]    raw_value;
    logic [SCALED_W-1:0] scaled_value;
    logic                divide_fault;

    modport source (output valid, output dataset_index, output raw_value,
                    output scaled_value, output divide_fault, input ready);
    modport sink   (input valid, input dataset_index, input raw_value,
                    input scaled_value, input divide_fault, output ready);
endinterface

/* design/btfe_cfg_bank.sv */
module btfe_cfg_bank #(
    parameter int NUM_DATASETS = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [btfe_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [btfe_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic [btfe_pkg::DS_W-1:0]         sel,
    output logic [btfe_pkg::PATTERN_W-1:0]    pattern,
    output btfe_pkg::btfe_format_t            format
);
    import btfe_pkg::*;

    logic [PATTERN_W-1:0] pattern_reg [NUM_DATASETS];
    btfe_format_t         format_reg  [NUM_DATASETS];
    logic                 pattern_we;
    logic                 format_we;

    always_comb
    begin
        pattern_we = 1'b0;
        format_we  = 1'b0;
        unique case (cfg_index[CFG_INDEX_W-1:2])
            CFG_GROUP_PATTERN: pattern_we = cfg_we;
            CFG_GROUP_FORMAT:  format_we  = cfg_we;
            default:           ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_DATASETS; i++)
            begin
                pattern_reg[i] <= '0;
                format_reg[i]  <= FORMAT_RESET;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_DATASETS; i++)
            begin
                if (pattern_we && cfg_index[1:0] == 2'(i))
                    pattern_reg[i] <= cfg_wdata;
                if (format_we && cfg_index[1:0] == 2'(i))
                    format_reg[i] <= cfg_wdata[FORMAT_W-1:0];
            end
        end
    end

    always_comb
    begin
        pattern = pattern_reg[0];
        format  = format_reg[0];
        for (int i = 1; i < NUM_DATASETS; i++)
        begin
            if (sel == DS_W'(i))
            begin
                pattern = pattern_reg[i];
                format  = format_reg[i];
            end
        end
    end

endmodule

/* design/btfe_divider.sv */
module btfe_divider #(
    parameter int DW = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [DW-1:0]                     dividend,
    input  logic [btfe_pkg::DIVISOR_W-1:0]    divisor,
    input  logic                              take,
    output btfe_pkg::btfe_div_status_t        status,
    output logic [DW-1:0]                     quotient
);
    import btfe_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0]        quo_reg, quo_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] div_reg;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;
    logic                 fits;

    // One restoring step: bring down the next dividend bit and try to subtract.
    assign trial = {rem_reg, quo_reg[DW-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CW'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DW-2:0], fits};
            rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (take)
        begin
            done_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
            div_reg <= divisor;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

/* design/bus_telegram_field_extractor.sv */
// Bus telegram field extractor.
//
// Bytes received from the bus arrive on the rx channel, one per transfer.
// The block walks the configured datasets in turn: it matches the header
// pattern of the current dataset, skips the configured number of bytes and
// gathers a one- or two-byte payload, low byte first. Each finished payload
// gives one transfer on the result channel with the dataset index, the raw
// value and the raw value divided by the divisor in fixed point.
//
// Header and skip bytes are taken as they arrive. A byte that completes a
// payload starts the shared restoring divider, which retires one quotient
// bit a cycle; rx is not ready until the quotient has left the divider.
// The result sits in an output register. If the receiver stalls, the next
// division still runs, but its answer waits in the divider and rx stays
// not ready until the output register has been emptied.
// Reset returns the parser to the header phase of dataset 0, empties the
// output register and loads the configuration reset values. Configuration
// is written through cfg_we, cfg_index and cfg_wdata while the block is
// idle; the user must keep to this, the block does not enforce it.
module bus_telegram_field_extractor #(
    parameter int NUM_DATASETS     = 4,
    parameter int MAX_HEADER_BYTES = 8,
    parameter int FRACTION_BITS    = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    btfe_byte_if.sink                         rx,
    btfe_result_if.source                     result,
    input  logic                              cfg_we,
    input  logic [btfe_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [btfe_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import btfe_pkg::*;

`include "bus_telegram_field_extractor_macros.svh"

    // The dividend is the raw value with the fraction bits appended.
    localparam int DW = RAW_W + FRACTION_BITS;

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_SKIP    = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;

    localparam logic [3:0] MAX_LEN = 4'(MAX_HEADER_BYTES);

    // Parser state.
    logic [1:0]        phase_reg, phase_next;
    logic [DS_W-1:0]   ds_reg, ds_next;
    logic [3:0]        byte_count_reg, byte_count_next;
    logic [7:0]        skipped_reg, skipped_next;
    logic [BYTE_W-1:0] low_byte_reg, low_byte_next;

    // Details of the division in flight, held until the result is loaded.
    logic [DS_W-1:0]   pend_ds_reg;
    logic [RAW_W-1:0]  pend_raw_reg;
    logic              pend_fault_reg;

    // Output register.
    logic                out_valid_reg;
    logic [DS_W-1:0]     out_ds_reg;
    logic [RAW_W-1:0]    out_raw_reg;
    logic [SCALED_W-1:0] out_scaled_reg;
    logic                out_fault_reg;

    logic [PATTERN_W-1:0] pattern;
    btfe_format_t         format;
    btfe_div_status_t     div_st;
    logic [DW-1:0]        quotient;

    logic              accept;
    logic              launch;
    logic              load;
    logic [RAW_W-1:0]  raw;
    logic [3:0]        header_len;
    logic [BYTE_W-1:0] want;
    logic [4:0]        hdr_next;
    logic [8:0]        skip_next;
    logic [31:0]       quo_wide;
    logic [SCALED_W-1:0] scaled;

    btfe_cfg_bank #(
        .NUM_DATASETS (NUM_DATASETS)
    ) u_cfg_bank (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .sel       (ds_reg),
        .pattern   (pattern),
        .format    (format)
    );

    btfe_divider #(
        .DW (DW)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (launch),
        .dividend (DW'(raw) << FRACTION_BITS),
        .divisor  (format.divisor),
        .take     (load),
        .status   (div_st),
        .quotient (quotient)
    );

    // The parser only takes a byte when no division is running or waiting.
    assign rx.ready = !div_st.busy && !div_st.done;
    assign accept   = rx.valid && rx.ready;

    // A header length of zero counts as one; anything above the limit is
    // clipped to the limit.
    always_comb
    begin
        if (format.header_len == 4'd0)
            header_len = 4'd1;
        else if (format.header_len > MAX_LEN)
            header_len = MAX_LEN;
        else
            header_len = format.header_len;
    end

    assign want      = pattern[{byte_count_reg[2:0], 3'b000} +: BYTE_W];
    assign hdr_next  = {1'b0, byte_count_reg} + 5'd1;
    assign skip_next = {1'b0, skipped_reg} + 9'd1;
    assign raw       = format.two_byte ? {rx.rx_byte, low_byte_reg}
                                       : RAW_W'(rx.rx_byte);

    always_comb
    begin
        phase_next      = phase_reg;
        ds_next         = ds_reg;
        byte_count_next = byte_count_reg;
        skipped_next    = skipped_reg;
        low_byte_next   = low_byte_reg;
        launch          = 1'b0;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (rx.rx_byte == want)
                    begin
                        if (hdr_next >= {1'b0, header_len})
                        begin
                            byte_count_next = '0;
                            skipped_next    = '0;
                            phase_next = (format.skip_count == 8'd0) ? PH_PAYLOAD
                                                                     : PH_SKIP;
                        end
                        else
                        begin
                            byte_count_next = hdr_next[3:0];
                        end
                    end
                    else
                    begin
                        // A mismatching byte is dropped, not retried as a
                        // new header start.
                        byte_count_next = '0;
                    end
                end
                PH_SKIP:
                begin
                    if (skip_next >= {1'b0, format.skip_count})
                    begin
                        skipped_next    = '0;
                        byte_count_next = '0;
                        phase_next      = PH_PAYLOAD;
                    end
                    else
                    begin
                        skipped_next = skip_next[7:0];
                    end
                end
                PH_PAYLOAD:
                begin
                    if (format.two_byte && byte_count_reg == 4'd0)
                    begin
                        low_byte_next   = rx.rx_byte;
                        byte_count_next = 4'd1;
                    end
                    else
                    begin
                        launch          = 1'b1;
                        byte_count_next = '0;
                        phase_next      = PH_HEADER;
                        ds_next = (ds_reg == DS_W'(NUM_DATASETS - 1)) ? '0
                                                                      : ds_reg + 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_HEADER;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            ds_reg         <= '0;
            byte_count_reg <= '0;
            skipped_reg    <= '0;
            low_byte_reg   <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            ds_reg         <= ds_next;
            byte_count_reg <= byte_count_next;
            skipped_reg    <= skipped_next;
            low_byte_reg   <= low_byte_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (launch)
        begin
            pend_ds_reg    <= ds_reg;
            pend_raw_reg   <= raw;
            pend_fault_reg <= (format.divisor == '0);
        end
    end

    // A finished quotient moves into the output register once it is free.
    assign load     = div_st.done && (!out_valid_reg || result.ready);
    assign quo_wide = 32'(quotient);

    always_comb
    begin
        if (pend_fault_reg || quo_wide > 32'(SCALED_MAX))
            scaled = SCALED_MAX;
        else
            scaled = quo_wide[SCALED_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_ds_reg     <= pend_ds_reg;
            out_raw_reg    <= pend_raw_reg;
            out_scaled_reg <= scaled;
            out_fault_reg  <= pend_fault_reg;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.dataset_index = out_ds_reg;
    assign result.raw_value     = out_raw_reg;
    assign result.scaled_value  = out_scaled_reg;
    assign result.divide_fault  = out_fault_reg;

    // A new result only appears after the divider has finished.
    `BTFE_ASSERT(a_result_from_divider, clk, rst_n, $rose(out_valid_reg) |-> $past(div_st.done))
    // A completed payload always sets the divider going.
    `BTFE_ASSERT(a_launch_starts_divider, clk, rst_n, launch |=> div_st.busy)
    // A flagged zero divisor always reports the saturated quotient.
    `BTFE_ASSERT_NEVER(a_fault_saturates, clk, rst_n, out_valid_reg && out_fault_reg && out_scaled_reg != SCALED_MAX)

endmodule
